// ===== sv/itra_pkg.sv =====
// itra_pkg: shared types, constants and helpers for the integer to radix ASCII converter.
// Used by itra_front, itra_queue, itra_back and integer_to_radix_ascii_core.
// No dependencies.
package itra_pkg;

  localparam int ValueWidth    = 32;
  localparam int DigitMax      = ValueWidth;
  localparam int DigitIdxW     = $clog2(DigitMax);
  localparam int BitsPerCycle  = 8;
  localparam int CyclesPerDigit = ValueWidth / BitsPerCycle;
  localparam int CycW          = (CyclesPerDigit > 1) ? $clog2(CyclesPerDigit) : 1;

  localparam logic [5:0] RadixMin = 6'd2;
  localparam logic [5:0] RadixMax = 6'd36;
  localparam logic [5:0] RadixDec = 6'd10;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharNone  = 8'h00;

  // One classified conversion job, as it travels from front to back.
  typedef struct packed {
    logic [ValueWidth-1:0] magnitude;
    logic [5:0]            radix;
    logic                  negative;
    logic                  upper;
    logic                  bad_radix;
  } itra_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SEND
  } itra_state_e;

  // Map a digit value (0 to 35) to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic up);
    logic [7:0] base;
    base = up ? CharUpA : CharLowA;
    if (d < 6'd10) begin
      return CharZero + {2'b00, d};
    end else begin
      return base + {2'b00, d} - 8'd10;
    end
  endfunction

endpackage

// ===== sv/integer_to_radix_ascii_core.sv =====
// integer_to_radix_ascii_core: top level of the integer to radix ASCII converter.
// Depends on itra_pkg, itra_front, itra_queue and itra_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: a 32-bit value,
//   a radix, a signed-mode flag and an upper-case flag. Output channel
//   (out_valid_o / out_stall_i) carries one ASCII character per item, most
//   significant digit first, with last_char_o set on the final character.
//   In signed mode with radix ten a negative value yields a leading '-'.
//   A radix outside 2..36 yields one item with radix_error_o and last_char_o
//   set and out_char_o zero.
// Timing:
//   The front classifies an item in the cycle it is accepted and drops it into
//   a two-entry queue, so in_stall_o rises only when the queue is full.
//   The back divides by the radix eight quotient bits per cycle. For each
//   character it then does a stack read, then an output register load.
// Reset and stall:
//   Reset empties the queue, idles the back and drops any pending character.
//   While the receiver stalls, hold the output register; the back finishes
//   any division under way and then waits before its next character.
//   The queue still accepts items until it fills.
module integer_to_radix_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] number_bits_i,
  input  logic [5:0]  radix_i,
  input  logic        signed_mode_i,
  input  logic        upper_letters_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o,
  output logic        radix_error_o
);

  itra_pkg::itra_job_t front_job;
  itra_pkg::itra_job_t back_job;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;

  // Classify the incoming item.
  itra_front u_front (
    .number_bits_i  (number_bits_i),
    .radix_i        (radix_i),
    .signed_mode_i  (signed_mode_i),
    .upper_letters_i(upper_letters_i),
    .job_o          (front_job)
  );

  // Decouple acceptance from conversion.
  itra_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_valid_i),
    .push_job_i(front_job),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .pop_job_o (back_job),
    .empty_o   (q_empty)
  );

  assign in_stall_o = q_full;

  // Divide, stack the digits and emit the characters.
  itra_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (back_job),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .radix_error_o(radix_error_o)
  );

endmodule

// ===== sv/itra_front.sv =====
// itra_front: classifies an incoming item (radix check, sign, magnitude).
// Depends on itra_pkg.
module itra_front (
  input  logic [31:0]          number_bits_i,
  input  logic [5:0]           radix_i,
  input  logic                 signed_mode_i,
  input  logic                 upper_letters_i,
  output itra_pkg::itra_job_t  job_o
);

  logic [itra_pkg::ValueWidth-1:0] value;
  logic                            neg;

  always_comb begin
    value = number_bits_i[itra_pkg::ValueWidth-1:0];
    neg   = signed_mode_i && (radix_i == itra_pkg::RadixDec) &&
            value[itra_pkg::ValueWidth-1];

    job_o.bad_radix = !(radix_i inside {[itra_pkg::RadixMin:itra_pkg::RadixMax]});
    job_o.negative  = neg;
    // Two's complement negate; the most negative value maps onto itself, which
    // is its true unsigned magnitude.
    job_o.magnitude = neg ? (~value + 1'b1) : value;
    job_o.radix     = radix_i;
    job_o.upper     = upper_letters_i;
  end

endmodule

// ===== sv/itra_queue.sv =====
// itra_queue: two-entry job queue between the front and the back.
// Depends on itra_pkg.
module itra_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  itra_pkg::itra_job_t push_job_i,
  output logic                full_o,
  input  logic                pop_i,
  output itra_pkg::itra_job_t pop_job_o,
  output logic                empty_o
);

  itra_pkg::itra_job_t slot_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          fill_q;

  assign full_o    = (fill_q == 2'd2);
  assign empty_o   = (fill_q == 2'd0);
  assign pop_job_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== sv/itra_back.sv =====
// itra_back: digit divider, digit stack and character sequencer.
// Depends on itra_pkg; fed by itra_queue.
module itra_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itra_pkg::itra_job_t job_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_char_o,
  output logic                last_char_o,
  output logic                radix_error_o
);

  localparam int VW = itra_pkg::ValueWidth;
  localparam int BW = itra_pkg::BitsPerCycle;

  itra_pkg::itra_state_e state_q, state_d;

  logic [VW-1:0]                   work_q, work_d;
  logic [5:0]                      rem_q, rem_d;
  logic [5:0]                      radix_q, radix_d;
  logic                            neg_q, neg_d;
  logic                            upper_q, upper_d;
  logic [itra_pkg::CycW-1:0]       cyc_q, cyc_d;
  logic [itra_pkg::DigitIdxW-1:0]  cnt_q, cnt_d;
  logic [itra_pkg::DigitIdxW-1:0]  idx_q, idx_d;

  logic                            out_valid_q, out_valid_d;
  logic [7:0]                      out_char_q, out_char_d;
  logic                            last_q, last_d;
  logic                            err_q, err_d;
  logic                            out_free;

  logic [5:0]                      stack_mem [itra_pkg::DigitMax];
  logic [5:0]                      rd_data_q;
  logic                            st_we, st_re;

  // Divider step results.
  logic [6:0]                      part;
  logic [BW-1:0]                   qbits;
  logic [VW-1:0]                   work_next;

  assign out_free = !out_valid_q || !out_stall_i;

  // Restoring division of the top BW bits of the work word per cycle.
  always_comb begin
    part  = (cyc_q == '0) ? 7'd0 : {1'b0, rem_q};
    qbits = '0;
    for (int k = 0; k < BW; k++) begin
      part = {part[5:0], work_q[VW-1-k]};
      if (part >= {1'b0, radix_q}) begin
        part           = part - {1'b0, radix_q};
        qbits[BW-1-k]  = 1'b1;
      end
    end
    work_next = {work_q[VW-BW-1:0], qbits};
  end

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    neg_d       = neg_q;
    upper_d     = upper_q;
    cyc_d       = cyc_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    last_d      = last_q;
    err_d       = err_q;
    pop_o       = 1'b0;
    st_we       = 1'b0;
    st_re       = 1'b0;

    case (state_q)
      itra_pkg::ST_IDLE: begin
        if (!empty_i) begin
          if (job_i.bad_radix) begin
            if (out_free) begin
              pop_o       = 1'b1;
              out_valid_d = 1'b1;
              out_char_d  = itra_pkg::CharNone;
              last_d      = 1'b1;
              err_d       = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            work_d  = job_i.magnitude;
            radix_d = job_i.radix;
            neg_d   = job_i.negative;
            upper_d = job_i.upper;
            cyc_d   = '0;
            cnt_d   = '0;
            state_d = itra_pkg::ST_DIV;
          end
        end
      end
      itra_pkg::ST_DIV: begin
        work_d = work_next;
        rem_d  = part[5:0];
        cyc_d  = cyc_q + 1'b1;
        if (cyc_q == itra_pkg::CycW'(itra_pkg::CyclesPerDigit - 1)) begin
          st_we = 1'b1;
          cyc_d = '0;
          cnt_d = cnt_q + 1'b1;
          if (work_next == '0 ||
              cnt_q == itra_pkg::DigitIdxW'(itra_pkg::DigitMax - 1)) begin
            idx_d   = cnt_q;
            state_d = neg_q ? itra_pkg::ST_SIGN : itra_pkg::ST_READ;
          end
        end
      end
      itra_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itra_pkg::CharMinus;
          last_d      = 1'b0;
          err_d       = 1'b0;
          state_d     = itra_pkg::ST_READ;
        end
      end
      itra_pkg::ST_READ: begin
        st_re   = 1'b1;
        state_d = itra_pkg::ST_SEND;
      end
      itra_pkg::ST_SEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itra_pkg::digit_char(rd_data_q, upper_q);
          last_d      = (idx_q == '0);
          err_d       = 1'b0;
          if (idx_q == '0) begin
            state_d = itra_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = itra_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = itra_pkg::ST_IDLE;
      end
    endcase
  end

  // Digit stack: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[cnt_q] <= part[5:0];
    end
    if (st_re) begin
      rd_data_q <= stack_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    upper_q    <= upper_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    last_q     <= last_d;
    err_q      <= err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itra_pkg::ST_IDLE;
      cyc_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cyc_q       <= cyc_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_char_o   = last_q;
  assign radix_error_o = err_q;

endmodule
